FILE: sv/pgvc_pkg.sv
`default_nettype none
package pgvc_pkg;

	localparam int DATA_W   = 32;
	localparam int COEF_W   = 32;
	localparam int FRAC_W   = 24;
	localparam int MAX_X    = 64;
	localparam int MAX_Y    = 64;
	localparam int MAX_Z    = 4096;
	localparam int MIN_SIZE = 3;

	localparam int XW  = $clog2(MAX_X);
	localparam int YW  = $clog2(MAX_Y);
	localparam int ZW  = $clog2(MAX_Z);
	localparam int XCW = 7;
	localparam int YCW = 7;
	localparam int ZCW = 13;

	localparam int DADDR_W = XW + YW;
	localparam int PADDR_W = DADDR_W + 1;
	localparam int PLANE_CELLS = MAX_X * MAX_Y;

	localparam int G_W    = DATA_W + 1;
	localparam int PROD_W = G_W + COEF_W + 1;
	localparam int SC_W   = PROD_W - FRAC_W;
	localparam int R_W    = SC_W + 1;

	localparam logic OP_CELL  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = 3'd5;

	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] pressure;
		logic signed [DATA_W-1:0] u_star;
		logic signed [DATA_W-1:0] v_star;
		logic signed [DATA_W-1:0] w_star;
		logic                     fluid;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] u_out;
		logic signed [DATA_W-1:0] v_out;
		logic signed [DATA_W-1:0] w_out;
		logic                     corrected;
		logic                     final_cell;
	} out_item_t;

	typedef struct packed {
		logic          fluid;
		logic [DATA_W-1:0] w;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] u;
	} dly_t;

	typedef struct packed {
		logic [ZW-1:0] z;
		logic [YW-1:0] y;
		logic [XW-1:0] x;
	} pos_t;

	// read and write addresses for one transaction
	typedef struct packed {
		logic               we;
		logic [PADDR_W-1:0] p_waddr;
		logic [PADDR_W-1:0] xp;
		logic [PADDR_W-1:0] xm;
		logic [PADDR_W-1:0] yp;
		logic [PADDR_W-1:0] ym;
		logic [PADDR_W-1:0] zm;
		logic [DADDR_W-1:0] d_waddr;
		logic [DADDR_W-1:0] d_raddr;
	} mem_req_t;

	typedef struct packed {
		logic                     emit;
		logic                     pre_int;
		logic                     final_cell;
		logic signed [DATA_W-1:0] pnext;
	} issue_t;

	function automatic logic [XCW-1:0] clamp7(input logic [XCW-1:0] v,
			input logic [XCW-1:0] hi);
		logic [XCW-1:0] r;
		r = v;
		if (v < XCW'(MIN_SIZE)) r = XCW'(MIN_SIZE);
		else if (v > hi) r = hi;
		return r;
	endfunction

	function automatic logic [ZCW-1:0] clamp_z(input logic [ZCW-1:0] v);
		logic [ZCW-1:0] r;
		r = v;
		if (v < ZCW'(MIN_SIZE)) r = ZCW'(MIN_SIZE);
		else if (v > ZCW'(MAX_Z)) r = ZCW'(MAX_Z);
		return r;
	endfunction

	function automatic pos_t step_pos(input pos_t p, input logic [XCW-1:0] ex,
			input logic [YCW-1:0] ey, input logic [ZCW-1:0] ez);
		pos_t n;
		n = p;
		if ({1'b0, p.x} + XCW'(1) < ex) begin
			n.x = p.x + XW'(1);
		end else begin
			n.x = '0;
			if ({1'b0, p.y} + YCW'(1) < ey) begin
				n.y = p.y + YW'(1);
			end else begin
				n.y = '0;
				n.z = ({1'b0, p.z} + ZCW'(1) < ez) ? p.z + ZW'(1) : '0;
			end
		end
		return n;
	endfunction

	function automatic logic [DATA_W-1:0] sat_data(input logic [R_W-1:0] r);
		logic [DATA_W-1:0] q;
		if (&r[R_W-1:DATA_W-1] || ~|r[R_W-1:DATA_W-1]) q = r[DATA_W-1:0];
		else if (r[R_W-1]) q = {1'b1, {(DATA_W-1){1'b0}}};
		else q = {1'b0, {(DATA_W-1){1'b1}}};
		return q;
	endfunction

endpackage
`default_nettype wire

FILE: sv/pressure_gradient_velocity_correct.sv
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_data   (op, pressure, u/v/w star, fluid)
// out       output     out_valid/out_stall out_data (u/v/w out, corrected, final_cell)
// cfg       input      cfg_we             cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low. The window and
// delay RAMs are read and written in the acceptance cycle, then the gradient,
// multiply and saturate stages follow, the last one writing the output register.
// Reset clears positions, valid bits and config (sizes 64, coefficients 0); the
// RAM contents are not cleared. Stall propagates back stage by stage, so bubbles
// close up and in_stall rises only when all four stages hold data.
`default_nettype none
module pressure_gradient_velocity_correct (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire pgvc_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output pgvc_pkg::out_item_t                    out_data,
	input  wire logic                              cfg_we,
	input  wire logic [pgvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pgvc_pkg::COEF_W-1:0]       cfg_data
);

	logic [pgvc_pkg::XCW-1:0] ex_q;
	logic [pgvc_pkg::YCW-1:0] ey_q;
	logic [pgvc_pkg::ZCW-1:0] ez_q;
	logic [pgvc_pkg::COEF_W-1:0] coef_x_q, coef_y_q, coef_z_q;
	logic ready, acc;
	pgvc_pkg::mem_req_t req;
	pgvc_pkg::issue_t issue;
	pgvc_pkg::dly_t dly_wdata, dly_rdata;
	logic [pgvc_pkg::DATA_W-1:0] p_xp, p_xm, p_yp, p_ym, p_zm;

	assign in_stall = !ready;
	assign acc      = in_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_q     <= pgvc_pkg::XCW'(pgvc_pkg::MAX_X);
			ey_q     <= pgvc_pkg::YCW'(pgvc_pkg::MAX_Y);
			ez_q     <= pgvc_pkg::ZCW'(64);
			coef_x_q <= '0;
			coef_y_q <= '0;
			coef_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pgvc_pkg::REG_SIZE_X: ex_q <= pgvc_pkg::clamp7(cfg_data[pgvc_pkg::XCW-1:0],
					pgvc_pkg::XCW'(pgvc_pkg::MAX_X));
				pgvc_pkg::REG_SIZE_Y: ey_q <= pgvc_pkg::clamp7(cfg_data[pgvc_pkg::YCW-1:0],
					pgvc_pkg::YCW'(pgvc_pkg::MAX_Y));
				pgvc_pkg::REG_SIZE_Z: ez_q <= pgvc_pkg::clamp_z(cfg_data[pgvc_pkg::ZCW-1:0]);
				pgvc_pkg::REG_COEF_X: coef_x_q <= cfg_data;
				pgvc_pkg::REG_COEF_Y: coef_y_q <= cfg_data;
				pgvc_pkg::REG_COEF_Z: coef_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pgvc_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.acc   (acc),
		.item  (in_data),
		.ex    (ex_q),
		.ey    (ey_q),
		.ez    (ez_q),
		.req   (req),
		.issue (issue)
	);

	// three copies of the pressure window to get five reads per cycle
	pgvc_ram #(.DEPTH(2 * pgvc_pkg::PLANE_CELLS), .WIDTH(pgvc_pkg::DATA_W)) u_pw_x (
		.clk(clk), .en(acc), .we(req.we), .waddr(req.p_waddr), .wdata(in_data.pressure),
		.raddr_a(req.xp), .raddr_b(req.xm), .rdata_a(p_xp), .rdata_b(p_xm)
	);

	pgvc_ram #(.DEPTH(2 * pgvc_pkg::PLANE_CELLS), .WIDTH(pgvc_pkg::DATA_W)) u_pw_y (
		.clk(clk), .en(acc), .we(req.we), .waddr(req.p_waddr), .wdata(in_data.pressure),
		.raddr_a(req.yp), .raddr_b(req.ym), .rdata_a(p_yp), .rdata_b(p_ym)
	);

	pgvc_ram #(.DEPTH(2 * pgvc_pkg::PLANE_CELLS), .WIDTH(pgvc_pkg::DATA_W)) u_pw_z (
		.clk(clk), .en(acc), .we(req.we), .waddr(req.p_waddr), .wdata(in_data.pressure),
		.raddr_a(req.zm), .raddr_b(req.zm), .rdata_a(p_zm), .rdata_b()
	);

	always_comb begin
		dly_wdata.fluid = in_data.fluid;
		dly_wdata.u     = in_data.u_star;
		dly_wdata.v     = in_data.v_star;
		dly_wdata.w     = in_data.w_star;
	end

	pgvc_ram #(.DEPTH(pgvc_pkg::PLANE_CELLS), .WIDTH($bits(pgvc_pkg::dly_t))) u_dly (
		.clk(clk), .en(acc), .we(req.we), .waddr(req.d_waddr), .wdata(dly_wdata),
		.raddr_a(req.d_raddr), .raddr_b(req.d_raddr), .rdata_a(dly_rdata), .rdata_b()
	);

	pgvc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.issue    (issue),
		.ready    (ready),
		.dly      (dly_rdata),
		.p_xp     (p_xp),
		.p_xm     (p_xm),
		.p_yp     (p_yp),
		.p_ym     (p_ym),
		.p_zm     (p_zm),
		.coef_x   (coef_x_q),
		.coef_y   (coef_y_q),
		.coef_z   (coef_z_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

FILE: sv/pgvc_ram.sv
`default_nettype none
module pgvc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read sees the contents before this cycle's write
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
			if (we) mem[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

FILE: sv/pgvc_front.sv
`default_nettype none
module pgvc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        acc,
	input  wire pgvc_pkg::in_item_t          item,
	input  wire logic [pgvc_pkg::XCW-1:0]    ex,
	input  wire logic [pgvc_pkg::YCW-1:0]    ey,
	input  wire logic [pgvc_pkg::ZCW-1:0]    ez,
	output pgvc_pkg::mem_req_t               req,
	output pgvc_pkg::issue_t                 issue
);

	pgvc_pkg::pos_t in_pos_q, out_pos_q;
	logic pending, is_cell;

	assign pending = out_pos_q.z != in_pos_q.z;
	assign is_cell = item.op == pgvc_pkg::OP_CELL;

	always_comb begin
		req.we      = is_cell;
		req.p_waddr = {in_pos_q.z[0], in_pos_q.y, in_pos_q.x};
		req.d_waddr = {in_pos_q.y, in_pos_q.x};
		req.d_raddr = {out_pos_q.y, out_pos_q.x};
		req.xp      = {out_pos_q.z[0], out_pos_q.y, out_pos_q.x + pgvc_pkg::XW'(1)};
		req.xm      = {out_pos_q.z[0], out_pos_q.y, out_pos_q.x - pgvc_pkg::XW'(1)};
		req.yp      = {out_pos_q.z[0], out_pos_q.y + pgvc_pkg::YW'(1), out_pos_q.x};
		req.ym      = {out_pos_q.z[0], out_pos_q.y - pgvc_pkg::YW'(1), out_pos_q.x};
		// other plane of the window holds z-1
		req.zm      = {~out_pos_q.z[0], out_pos_q.y, out_pos_q.x};
	end

	always_comb begin
		issue.emit    = pending;
		issue.pnext   = item.pressure;
		issue.pre_int = is_cell
			&& out_pos_q.x != '0 && {1'b0, out_pos_q.x} + pgvc_pkg::XCW'(1) < ex
			&& out_pos_q.y != '0 && {1'b0, out_pos_q.y} + pgvc_pkg::YCW'(1) < ey
			&& out_pos_q.z != '0 && {1'b0, out_pos_q.z} + pgvc_pkg::ZCW'(1) < ez;
		issue.final_cell = {1'b0, out_pos_q.x} == ex - pgvc_pkg::XCW'(1)
			&& {1'b0, out_pos_q.y} == ey - pgvc_pkg::YCW'(1)
			&& {1'b0, out_pos_q.z} == ez - pgvc_pkg::ZCW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q  <= '0;
			out_pos_q <= '0;
		end else if (acc) begin
			if (pending) out_pos_q <= pgvc_pkg::step_pos(out_pos_q, ex, ey, ez);
			if (is_cell) in_pos_q <= pgvc_pkg::step_pos(in_pos_q, ex, ey, ez);
		end
	end

endmodule
`default_nettype wire

FILE: sv/pgvc_datapath.sv
`default_nettype none
module pgvc_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               acc,
	input  wire pgvc_pkg::issue_t                   issue,
	output logic                                    ready,
	input  wire pgvc_pkg::dly_t                     dly,
	input  wire logic [pgvc_pkg::DATA_W-1:0]        p_xp,
	input  wire logic [pgvc_pkg::DATA_W-1:0]        p_xm,
	input  wire logic [pgvc_pkg::DATA_W-1:0]        p_yp,
	input  wire logic [pgvc_pkg::DATA_W-1:0]        p_ym,
	input  wire logic [pgvc_pkg::DATA_W-1:0]        p_zm,
	input  wire logic [pgvc_pkg::COEF_W-1:0]        coef_x,
	input  wire logic [pgvc_pkg::COEF_W-1:0]        coef_y,
	input  wire logic [pgvc_pkg::COEF_W-1:0]        coef_z,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output pgvc_pkg::out_item_t                     out_data
);

	localparam int DW = pgvc_pkg::DATA_W;

	typedef struct packed {
		logic                  interior;
		logic                  final_cell;
		logic [DW-1:0]         u;
		logic [DW-1:0]         v;
		logic [DW-1:0]         w;
		logic [pgvc_pkg::G_W-1:0] gx;
		logic [pgvc_pkg::G_W-1:0] gy;
		logic [pgvc_pkg::G_W-1:0] gz;
	} grad_t;

	typedef struct packed {
		logic                      interior;
		logic                      final_cell;
		logic [DW-1:0]             u;
		logic [DW-1:0]             v;
		logic [DW-1:0]             w;
		logic [pgvc_pkg::SC_W-1:0] sx;
		logic [pgvc_pkg::SC_W-1:0] sy;
		logic [pgvc_pkg::SC_W-1:0] sz;
	} scaled_t;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	pgvc_pkg::issue_t issue_s1;
	grad_t   grad_d, grad_s2;
	scaled_t sc_d, sc_s3;
	pgvc_pkg::out_item_t res_d, res_s4;
	logic signed [pgvc_pkg::PROD_W-1:0] prod_x, prod_y, prod_z;
	logic [pgvc_pkg::R_W-1:0] ru, rv, rw;
	logic interior;

	assign rdy4  = !v_s4 || !out_stall;
	assign rdy3  = !v_s3 || rdy4;
	assign rdy2  = !v_s2 || rdy3;
	assign rdy1  = !v_s1 || rdy2;
	assign ready = rdy1;

	// stage 1: window read data lines up with issue_s1
	assign interior = issue_s1.pre_int && dly.fluid;

	always_comb begin
		grad_d.interior   = interior;
		grad_d.final_cell = issue_s1.final_cell;
		grad_d.u = dly.u;
		grad_d.v = dly.v;
		grad_d.w = dly.w;
		grad_d.gx = '0;
		grad_d.gy = '0;
		grad_d.gz = '0;
		if (interior) begin
			grad_d.gx = {p_xp[DW-1], p_xp} - {p_xm[DW-1], p_xm};
			grad_d.gy = {p_yp[DW-1], p_yp} - {p_ym[DW-1], p_ym};
			grad_d.gz = {issue_s1.pnext[DW-1], issue_s1.pnext} - {p_zm[DW-1], p_zm};
		end
	end

	// stage 2: signed product, arithmetic shift gives the floor
	assign prod_x = $signed(grad_s2.gx) * $signed({1'b0, coef_x});
	assign prod_y = $signed(grad_s2.gy) * $signed({1'b0, coef_y});
	assign prod_z = $signed(grad_s2.gz) * $signed({1'b0, coef_z});

	always_comb begin
		sc_d.interior   = grad_s2.interior;
		sc_d.final_cell = grad_s2.final_cell;
		sc_d.u  = grad_s2.u;
		sc_d.v  = grad_s2.v;
		sc_d.w  = grad_s2.w;
		sc_d.sx = prod_x[pgvc_pkg::PROD_W-1:pgvc_pkg::FRAC_W];
		sc_d.sy = prod_y[pgvc_pkg::PROD_W-1:pgvc_pkg::FRAC_W];
		sc_d.sz = prod_z[pgvc_pkg::PROD_W-1:pgvc_pkg::FRAC_W];
	end

	// stage 3: subtract and saturate
	assign ru = {{(pgvc_pkg::R_W-DW){sc_s3.u[DW-1]}}, sc_s3.u}
		- {sc_s3.sx[pgvc_pkg::SC_W-1], sc_s3.sx};
	assign rv = {{(pgvc_pkg::R_W-DW){sc_s3.v[DW-1]}}, sc_s3.v}
		- {sc_s3.sy[pgvc_pkg::SC_W-1], sc_s3.sy};
	assign rw = {{(pgvc_pkg::R_W-DW){sc_s3.w[DW-1]}}, sc_s3.w}
		- {sc_s3.sz[pgvc_pkg::SC_W-1], sc_s3.sz};

	always_comb begin
		res_d.u_out      = pgvc_pkg::sat_data(ru);
		res_d.v_out      = pgvc_pkg::sat_data(rv);
		res_d.w_out      = pgvc_pkg::sat_data(rw);
		res_d.corrected  = sc_s3.interior;
		res_d.final_cell = sc_s3.final_cell;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= acc && issue.emit;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) issue_s1 <= issue;
		if (rdy2 && v_s1) grad_s2 <= grad_d;
		if (rdy3 && v_s2) sc_s3 <= sc_d;
		if (rdy4 && v_s3) res_s4 <= res_d;
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule
`default_nettype wire

FILE: sv/pgvc_checker.sv
`default_nettype none
module pgvc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire pgvc_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid && !in_stall)
		else $error("activity during reset");

	// input backs up only once the output is full and held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// the last cell sits on the boundary and is never corrected
	a_final_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.corrected |-> !out_data.final_cell)
		else $error("last cell reported as corrected");

endmodule

bind pressure_gradient_velocity_correct pgvc_checker u_pgvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	pgvc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pgvc_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [pgvc_pkg::CFG_IDX_W-1:0] cfg_index = pgvc_pkg::REG_SIZE_X;
	logic [pgvc_pkg::COEF_W-1:0] cfg_data = '0;

	pressure_gradient_velocity_correct dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// shadow copy of the block state
	int unsigned raw_x, raw_y, raw_z;
	logic [31:0] k_x, k_y, k_z;
	logic signed [31:0] p_plane [0:2*pgvc_pkg::PLANE_CELLS-1];
	logic signed [31:0] u_line [0:pgvc_pkg::PLANE_CELLS-1];
	logic signed [31:0] v_line [0:pgvc_pkg::PLANE_CELLS-1];
	logic signed [31:0] w_line [0:pgvc_pkg::PLANE_CELLS-1];
	logic f_line [0:pgvc_pkg::PLANE_CELLS-1];
	int unsigned ix, iy, iz, ox, oy, oz;

	pgvc_pkg::out_item_t velocity_q[$];
	int errors = 0;
	int n_sent = 0;
	int burst_left = 0;
	int idle_mode = 1;

	function automatic int unsigned lim(int unsigned v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic next_cell(inout int unsigned x, inout int unsigned y, inout int unsigned z);
		if (x + 1 < lim(raw_x, pgvc_pkg::MAX_X)) x++;
		else begin
			x = 0;
			if (y + 1 < lim(raw_y, pgvc_pkg::MAX_Y)) y++;
			else begin
				y = 0;
				z = (z + 1 < lim(raw_z, pgvc_pkg::MAX_Z)) ? z + 1 : 0;
			end
		end
	endtask

	// floor(diff * coef / 2^24)
	function automatic logic signed [71:0] grad_term(logic signed [32:0] diff,
			logic [31:0] c);
		logic signed [71:0] prod;
		prod = diff * $signed({1'b0, c});
		return prod >>> pgvc_pkg::FRAC_W;
	endfunction

	function automatic logic [31:0] clip32(logic signed [71:0] r);
		if (r > 72'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (r < -72'sh80000000) return 32'h80000000;
		return r[31:0];
	endfunction

	task automatic correct_cell(bit has_up, logic signed [31:0] p_up);
		int unsigned ex, ey, ez, d, cp, pp;
		logic signed [71:0] uu, vv, ww;
		logic signed [32:0] gx, gy, gz;
		bit inner;
		pgvc_pkg::out_item_t r;
		ex = lim(raw_x, pgvc_pkg::MAX_X);
		ey = lim(raw_y, pgvc_pkg::MAX_Y);
		ez = lim(raw_z, pgvc_pkg::MAX_Z);
		d = oy * pgvc_pkg::MAX_X + ox;
		uu = u_line[d];
		vv = v_line[d];
		ww = w_line[d];
		inner = has_up && f_line[d] && ox >= 1 && ox + 1 < ex && oy >= 1 &&
			oy + 1 < ey && oz >= 1 && oz + 1 < ez;
		if (inner) begin
			cp = (oz & 1) * pgvc_pkg::PLANE_CELLS + d;
			pp = ((oz + 1) & 1) * pgvc_pkg::PLANE_CELLS + d;
			gx = p_plane[cp + 1] - p_plane[cp - 1];
			gy = p_plane[cp + pgvc_pkg::MAX_X] - p_plane[cp - pgvc_pkg::MAX_X];
			gz = p_up - p_plane[pp];
			uu = uu - grad_term(gx, k_x);
			vv = vv - grad_term(gy, k_y);
			ww = ww - grad_term(gz, k_z);
		end
		r.u_out = clip32(uu);
		r.v_out = clip32(vv);
		r.w_out = clip32(ww);
		r.corrected = inner;
		r.final_cell = (ox == ex - 1 && oy == ey - 1 && oz == ez - 1);
		velocity_q.push_back(r);
		next_cell(ox, oy, oz);
	endtask

	task automatic predict_cell(pgvc_pkg::in_item_t it);
		int unsigned d;
		bit due;
		due = (oz != iz);
		if (it.op == pgvc_pkg::OP_FLUSH) begin
			if (due) correct_cell(0, '0);
			return;
		end
		if (due) correct_cell(1, it.pressure);
		d = iy * pgvc_pkg::MAX_X + ix;
		p_plane[(iz & 1) * pgvc_pkg::PLANE_CELLS + d] = it.pressure;
		u_line[d] = it.u_star;
		v_line[d] = it.v_star;
		w_line[d] = it.w_star;
		f_line[d] = it.fluid;
		next_cell(ix, iy, iz);
	endtask

	// one input transaction, sender bursts and gaps
	task automatic send_item(pgvc_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (idle_mode == 0) ? 0 : $urandom_range(0, 6);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_cell(it);
		n_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (velocity_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic [pgvc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			pgvc_pkg::REG_SIZE_X: raw_x = val & 32'h7F;
			pgvc_pkg::REG_SIZE_Y: raw_y = val & 32'h7F;
			pgvc_pkg::REG_SIZE_Z: raw_z = val & 32'h1FFF;
			pgvc_pkg::REG_COEF_X: k_x = val;
			pgvc_pkg::REG_COEF_Y: k_y = val;
			pgvc_pkg::REG_COEF_Z: k_z = val;
			default: ;
		endcase
	endtask

	task automatic setup_grid(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		wait_drained();
		write_reg(pgvc_pkg::REG_SIZE_X, sx);
		write_reg(pgvc_pkg::REG_SIZE_Y, sy);
		write_reg(pgvc_pkg::REG_SIZE_Z, sz);
		write_reg(pgvc_pkg::REG_COEF_X, cx);
		write_reg(pgvc_pkg::REG_COEF_Y, cy);
		write_reg(pgvc_pkg::REG_COEF_Z, cz);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			2: case ($urandom_range(0, 3))
				0: return 32'h80000000;
				1: return 32'h7FFFFFFF;
				2: return 32'h0;
				default: return 32'hFFFFFFFF;
			endcase
			default: return $urandom_range(0, 32'h7FF) - 32'h400;
		endcase
	endfunction

	function automatic logic [31:0] rnd_coef();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h3FFFFFF);
		endcase
	endfunction

	function automatic pgvc_pkg::in_item_t rnd_cell();
		pgvc_pkg::in_item_t it;
		it.op = pgvc_pkg::OP_CELL;
		it.pressure = rnd_word();
		it.u_star = rnd_word();
		it.v_star = rnd_word();
		it.w_star = rnd_word();
		it.fluid = ($urandom_range(0, 7) != 0);
		return it;
	endfunction

	function automatic pgvc_pkg::in_item_t flush_item();
		pgvc_pkg::in_item_t it;
		it = rnd_cell();
		it.op = pgvc_pkg::OP_FLUSH;
		return it;
	endfunction

	task automatic drain_plane();
		while (oz != iz) send_item(flush_item());
	endtask

	task automatic test_directed();
		pgvc_pkg::in_item_t it;
		logic [31:0] ext [4];
		ext = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF};
		setup_grid(3, 3, 3, 32'hFFFFFFFF, 32'h01000000, 32'h00800000);
		send_item(flush_item());	// nothing due yet
		for (int i = 0; i < 27; i++) begin
			it.op = pgvc_pkg::OP_CELL;
			it.pressure = ext[i % 4];
			it.u_star = ext[(i + 1) % 4];
			it.v_star = ext[(i + 2) % 4];
			it.w_star = ext[(i + 3) % 4];
			it.fluid = (i != 4);
			if (i == 13) begin
				it.fluid = 1'b1;
				it.u_star = 32'h12345678;
			end
			send_item(it);
		end
		drain_plane();
		send_item(flush_item());
	endtask

	task automatic test_size_limits();
		// out-of-range sizes: small ones saturate up, large ones down
		setup_grid(0, 2, 1, 32'h00010000, 32'h00020000, 32'h00030000);
		repeat (27) send_item(rnd_cell());
		drain_plane();
		setup_grid(127, 0, 0, rnd_coef(), rnd_coef(), rnd_coef());
		repeat (64 * 3 * 3) send_item(rnd_cell());
		drain_plane();
		// deep z: run five planes, then shrink z so the positions wrap
		setup_grid(0, 0, 8191, rnd_coef(), rnd_coef(), rnd_coef());
		repeat (9 * 5) send_item(rnd_cell());
		drain_plane();
		setup_grid(0, 0, 3, rnd_coef(), rnd_coef(), rnd_coef());
		repeat (9 + 27) send_item(rnd_cell());
		drain_plane();
		setup_grid(64, 64, 4096, 0, 0, 0);
	endtask

	task automatic test_random_grids();
		int cells, grids;
		while (n_sent < 1850) begin
			idle_mode = $urandom_range(0, 3);
			setup_grid($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(1, 5),
				rnd_coef(), rnd_coef(), rnd_coef());
			grids = $urandom_range(1, 2);
			cells = grids * lim(raw_x, pgvc_pkg::MAX_X) * lim(raw_y, pgvc_pkg::MAX_Y)
				* lim(raw_z, pgvc_pkg::MAX_Z);
			for (int i = 0; i < cells; i++) begin
				if ($urandom_range(0, 40) == 0) send_item(flush_item());
				send_item(rnd_cell());
			end
			drain_plane();
		end
	endtask

	// receiver stall pattern
	int stall_mode = 0;
	int stall_cnt = 0;
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_cnt <= $urandom_range(64, 300);
			stall_mode <= $urandom_range(0, 3);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= (stall_cnt % 5 < 2);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		pgvc_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (velocity_q.size() == 0) begin
				$display("%0t unexpected transaction: got %h", $time, out_data);
				errors++;
			end else begin
				e = velocity_q.pop_front();
				if (out_data.u_out !== e.u_out) begin
					$display("%0t u_out exp %h got %h", $time, e.u_out, out_data.u_out);
					errors++;
				end
				if (out_data.v_out !== e.v_out) begin
					$display("%0t v_out exp %h got %h", $time, e.v_out, out_data.v_out);
					errors++;
				end
				if (out_data.w_out !== e.w_out) begin
					$display("%0t w_out exp %h got %h", $time, e.w_out, out_data.w_out);
					errors++;
				end
				if (out_data.corrected !== e.corrected) begin
					$display("%0t corrected exp %b got %b", $time, e.corrected,
						out_data.corrected);
					errors++;
				end
				if (out_data.final_cell !== e.final_cell) begin
					$display("%0t final_cell exp %b got %b", $time, e.final_cell,
						out_data.final_cell);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		raw_x = 64; raw_y = 64; raw_z = 64;
		k_x = '0; k_y = '0; k_z = '0;
		ix = 0; iy = 0; iz = 0; ox = 0; oy = 0; oz = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_size_limits();
		test_random_grids();
		wait_drained();
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
